// ===== rtl/brfifo_pkg.sv =====
`default_nettype none

package brfifo_pkg;

  localparam int DEPTH     = 4096;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int MAX_BURST = 64;
  localparam int BURST_W   = $clog2(MAX_BURST + 1);
  localparam int CNT_W     = 12;
  localparam int WIDE_W    = (PTR_W > CNT_W) ? PTR_W : CNT_W;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_CONSUME = 3'd3,
    OP_FLUSH   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOTHING   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_BURST
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/byte_ring_fifo_peek_consume_core.sv =====
`default_nettype none
// A push, consume, flush, empty or zero-count item gives its one result through the
// execute state and the result registers. A pop or peek of n bytes (n at most the burst
// limit) reads its first byte in the execute state, passes it through the read register
// and the burst state to the result registers, then gives one result per cycle. No new
// item is taken while busy is high. The receiver cannot stall the results.
// Reset clears both pointers and the control state; the byte store is not cleared.
module byte_ring_fifo_peek_consume_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  op_i,
  input  wire logic [7:0]  data_in_i,
  input  wire logic [11:0] count_i,
  output logic             result_strobe_o,
  output logic [7:0]       data_out_o,
  output logic             data_valid_o,
  output logic             last_o,
  output logic [1:0]       status_o,
  output logic [11:0]      moved_o,
  output logic [11:0]      occupancy_o
);

  localparam int PW = brfifo_pkg::PTR_W;
  localparam int BW = brfifo_pkg::BURST_W;
  localparam int WW = brfifo_pkg::WIDE_W;

  // Control state.
  brfifo_pkg::state_e state_q, state_d;
  logic [PW-1:0] wp_q, wp_d;
  logic [PW-1:0] rp_q, rp_d;

  // Latched command; the payload needs no reset.
  logic [2:0]    op_q;
  logic [7:0]    din_q;
  logic [11:0]   cnt_q;

  // Burst bookkeeping.
  logic [BW-1:0] len_q, len_d;
  logic [BW-1:0] beat_q, beat_d;
  logic [PW-1:0] raddr_q, raddr_d;
  logic [PW-1:0] avail_q, avail_d;

  // Byte store: one write port, one registered read port.
  logic [7:0]    mem [brfifo_pkg::DEPTH];
  logic          we;
  logic          re;
  logic [PW-1:0] raddr;
  logic [7:0]    rdata_q;

  // Result registers.
  logic          res_vld_q, res_vld_d;
  logic [7:0]    res_data_q, res_data_d;
  logic          res_dv_q, res_dv_d;
  logic          res_last_q, res_last_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [11:0]   res_moved_q, res_moved_d;
  logic [11:0]   res_occ_q, res_occ_d;

  // Helper values for the command being executed.
  logic [PW-1:0] avail;
  logic [PW-1:0] wp_inc;
  logic [WW-1:0] take;
  logic [BW-1:0] burst_n;
  logic          beat_last;

  assign avail  = wp_q - rp_q;
  assign wp_inc = wp_q + PW'(1);

  // Bytes that a consume removes: the smaller of the request and the fill level.
  always_comb begin
    if (WW'(cnt_q) < WW'(avail)) begin
      take = WW'(cnt_q);
    end else begin
      take = WW'(avail);
    end
  end

  // A pop or peek burst is further clamped to the burst limit.
  always_comb begin
    if (take > WW'(brfifo_pkg::MAX_BURST)) begin
      burst_n = BW'(brfifo_pkg::MAX_BURST);
    end else begin
      burst_n = BW'(take);
    end
  end

  assign beat_last = (beat_q + BW'(1)) == len_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      brfifo_pkg::S_IDLE: begin
        if (start) state_d = brfifo_pkg::S_EXEC;
      end
      brfifo_pkg::S_EXEC: begin
        if ((op_q == brfifo_pkg::OP_POP || op_q == brfifo_pkg::OP_PEEK) &&
            cnt_q != '0 && avail != '0) begin
          state_d = brfifo_pkg::S_BURST;
        end else begin
          state_d = brfifo_pkg::S_IDLE;
        end
      end
      brfifo_pkg::S_BURST: begin
        if (beat_last) state_d = brfifo_pkg::S_IDLE;
      end
      default: state_d = brfifo_pkg::S_IDLE;
    endcase
  end

  // Datapath and result formation.
  always_comb begin
    wp_d         = wp_q;
    rp_d         = rp_q;
    len_d        = len_q;
    beat_d       = beat_q;
    raddr_d      = raddr_q;
    avail_d      = avail_q;
    we           = 1'b0;
    re           = 1'b0;
    raddr        = raddr_q;
    res_vld_d    = 1'b0;
    res_data_d   = '0;
    res_dv_d     = 1'b0;
    res_last_d   = 1'b1;
    res_status_d = brfifo_pkg::ST_OK;
    res_moved_d  = '0;
    res_occ_d    = 12'(avail);
    case (state_q)
      brfifo_pkg::S_EXEC: begin
        res_vld_d = 1'b1;
        case (op_q)
          brfifo_pkg::OP_PUSH: begin
            if (wp_inc == rp_q) begin
              res_status_d = brfifo_pkg::ST_FULL;
            end else begin
              we          = 1'b1;
              wp_d        = wp_inc;
              res_moved_d = 12'd1;
              res_occ_d   = 12'(avail + PW'(1));
            end
          end
          brfifo_pkg::OP_POP, brfifo_pkg::OP_PEEK: begin
            if (cnt_q == '0) begin
              res_status_d = brfifo_pkg::ST_OK;
            end else if (avail == '0) begin
              res_status_d = brfifo_pkg::ST_NOTHING;
            end else begin
              // Results come from the burst state; fetch the first byte now.
              res_vld_d = 1'b0;
              re        = 1'b1;
              raddr     = rp_q;
              raddr_d   = rp_q + PW'(1);
              len_d     = burst_n;
              beat_d    = '0;
              avail_d   = avail;
            end
          end
          brfifo_pkg::OP_CONSUME: begin
            if (cnt_q == '0) begin
              res_status_d = brfifo_pkg::ST_OK;
            end else if (avail == '0) begin
              res_status_d = brfifo_pkg::ST_NOTHING;
            end else begin
              rp_d        = rp_q + PW'(take);
              res_moved_d = 12'(take);
              res_occ_d   = 12'(avail - PW'(take));
            end
          end
          brfifo_pkg::OP_FLUSH: begin
            wp_d      = '0;
            rp_d      = '0;
            res_occ_d = '0;
          end
          default: begin
            res_status_d = brfifo_pkg::ST_OK;
          end
        endcase
      end
      brfifo_pkg::S_BURST: begin
        // The byte for this beat sits in the read register; fetch the next one.
        res_vld_d   = 1'b1;
        res_data_d  = rdata_q;
        res_dv_d    = 1'b1;
        res_last_d  = beat_last;
        res_moved_d = 12'(beat_q + BW'(1));
        if (op_q == brfifo_pkg::OP_POP) begin
          res_occ_d = 12'(avail_q - PW'(beat_q + BW'(1)));
        end else begin
          res_occ_d = 12'(avail_q);
        end
        if (beat_last) begin
          if (op_q == brfifo_pkg::OP_POP) rp_d = rp_q + PW'(len_q);
        end else begin
          re      = 1'b1;
          raddr   = raddr_q;
          raddr_d = raddr_q + PW'(1);
          beat_d  = beat_q + BW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= brfifo_pkg::S_IDLE;
      wp_q      <= '0;
      rp_q      <= '0;
      len_q     <= '0;
      beat_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      len_q     <= len_d;
      beat_q    <= beat_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == brfifo_pkg::S_IDLE && start) begin
      op_q  <= op_i;
      din_q <= data_in_i;
      cnt_q <= count_i;
    end
    raddr_q      <= raddr_d;
    avail_q      <= avail_d;
    res_data_q   <= res_data_d;
    res_dv_q     <= res_dv_d;
    res_last_q   <= res_last_d;
    res_status_q <= res_status_d;
    res_moved_q  <= res_moved_d;
    res_occ_q    <= res_occ_d;
  end

  // Only one command runs at a time, so a write and a read of the same entry
  // never overlap and the store needs no forwarding.
  always_ff @(posedge clk_i) begin
    if (we) mem[wp_q] <= din_q;
  end

  always_ff @(posedge clk_i) begin
    if (re) rdata_q <= mem[raddr];
  end

  assign busy            = state_q != brfifo_pkg::S_IDLE;
  assign result_strobe_o = res_vld_q;
  assign data_out_o      = res_data_q;
  assign data_valid_o    = res_dv_q;
  assign last_o          = res_last_q;
  assign status_o        = res_status_q;
  assign moved_o         = res_moved_q;
  assign occupancy_o     = res_occ_q;

  // A result is only produced by a command that was executing in the cycle before.
  a_strobe_follows_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(state_q) != brfifo_pkg::S_IDLE)
    else $error("result strobe without an executing command");

  // A burst always has a nonzero length and its beat stays below it.
  a_burst_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == brfifo_pkg::S_BURST |-> (len_q != '0 && beat_q < len_q))
    else $error("burst beat outside its length");

  // Every byte-carrying result reports success.
  a_byte_result_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && data_valid_o) |-> status_o == brfifo_pkg::ST_OK)
    else $error("byte result with error status");

endmodule

`default_nettype wire
